### hw/rtl/rbsi_pkg.sv
package rbsi_pkg;

  localparam int unsigned NumAxes  = 3;
  localparam int unsigned NumDivs  = 2 * NumAxes;
  localparam int unsigned DivSteps = 33;

  typedef enum logic [2:0] {
    CFG_BOX_MIN_X = 3'd0,
    CFG_BOX_MIN_Y = 3'd1,
    CFG_BOX_MIN_Z = 3'd2,
    CFG_BOX_MAX_X = 3'd3,
    CFG_BOX_MAX_Y = 3'd4,
    CFG_BOX_MAX_Z = 3'd5,
    CFG_PAR_THR   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] quo;
    logic [32:0] nlo;
    logic [31:0] den;
    logic        neg;
    logic        ovf;
  } div_t;

  typedef struct packed {
    logic                       valid;
    div_t [NumDivs-1:0]         dv;
    logic [NumAxes-1:0]         par;
    logic [NumAxes-1:0]         ins;
  } pipe_t;

  typedef struct packed {
    logic                           valid;
    logic [NumAxes-1:0][31:0]       lo;
    logic [NumAxes-1:0][31:0]       hi;
    logic [NumAxes-1:0]             par;
    logic [NumAxes-1:0]             ins;
  } sort_t;

  // One restoring division step: one quotient bit per call.
  function automatic div_t div_step(div_t x);
    div_t        y;
    logic [32:0] trial;
    y     = x;
    trial = {1'b0, x.rem[30:0], x.nlo[32]} - {1'b0, x.den};
    y.nlo = {x.nlo[31:0], 1'b0};
    if (!trial[32]) begin
      y.rem = trial[31:0];
      y.quo = {x.quo[31:0], 1'b1};
    end else begin
      y.rem = {x.rem[30:0], x.nlo[32]};
      y.quo = {x.quo[31:0], 1'b0};
    end
    return y;
  endfunction

  // Applies the sign and saturates to signed Q16.16.
  function automatic logic [31:0] div_sat(div_t x);
    logic [31:0] r;
    if (x.neg) begin
      if (x.ovf || x.quo[32] || (x.quo[31] && (|x.quo[30:0]))) begin
        r = 32'h8000_0000;
      end else begin
        r = 32'd0 - x.quo[31:0];
      end
    end else begin
      if (x.ovf || x.quo[32] || x.quo[31]) begin
        r = 32'h7FFF_FFFF;
      end else begin
        r = x.quo[31:0];
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/ray_box_slab_intersect.sv
// Throughput: one ray per cycle while the output is not stalled.
// Six 33-stage restoring dividers set the depth.
// The whole pipeline advances together and holds while a result waits unaccepted.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the box registers
// with zero and the parallel threshold with one.
module ray_box_slab_intersect (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_distance, zero filled
  output logic [31:0]  m_axis_tdata,
  // hit
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import rbsi_pkg::*;

  logic [NumAxes-1:0][31:0] box_min_q;
  logic [NumAxes-1:0][31:0] box_max_q;
  logic [30:0]              thr_q;

  pipe_t                    pipe_q [DivSteps+1];
  pipe_t                    pipe_d [DivSteps+1];
  sort_t                    sort_q, sort_d;
  logic                     out_valid_q, out_hit_q, out_hit_d;
  logic [30:0]              out_dist_q, out_dist_d;
  logic                     en;

  assign cfg_ready_o   = 1'b1;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min_q <= '0;
      box_max_q <= '0;
      thr_q     <= 31'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BOX_MIN_X: box_min_q[0] <= cfg_data_i;
        CFG_BOX_MIN_Y: box_min_q[1] <= cfg_data_i;
        CFG_BOX_MIN_Z: box_min_q[2] <= cfg_data_i;
        CFG_BOX_MAX_X: box_max_q[0] <= cfg_data_i;
        CFG_BOX_MAX_Y: box_max_q[1] <= cfg_data_i;
        CFG_BOX_MAX_Z: box_max_q[2] <= cfg_data_i;
        CFG_PAR_THR:   thr_q        <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [31:0] org;
    logic [31:0] dir;
    logic [31:0] dmag;
    logic [31:0] bnd;
    logic [32:0] diff;
    logic [32:0] dabs;
    pipe_d[0]       = '0;
    pipe_d[0].valid = s_axis_tvalid;
    for (int a = 0; a < NumAxes; a++) begin
      org  = s_axis_tdata[32*a +: 32];
      dir  = s_axis_tdata[32*(a+NumAxes) +: 32];
      dmag = dir[31] ? (32'd0 - dir) : dir;
      pipe_d[0].par[a] = (dir == 32'd0) || (dmag < {1'b0, thr_q});
      pipe_d[0].ins[a] = ($signed(org) >= $signed(box_min_q[a])) &&
                         ($signed(org) <= $signed(box_max_q[a]));
      for (int b = 0; b < 2; b++) begin
        bnd  = (b == 0) ? box_min_q[a] : box_max_q[a];
        diff = {bnd[31], bnd} - {org[31], org};
        dabs = diff[32] ? (33'd0 - diff) : diff;
        pipe_d[0].dv[2*a+b].den = dmag;
        pipe_d[0].dv[2*a+b].neg = diff[32] ^ dir[31];
        pipe_d[0].dv[2*a+b].ovf = {16'd0, dabs[32:17]} >= dmag;
        pipe_d[0].dv[2*a+b].rem = pipe_d[0].dv[2*a+b].ovf ? 32'd0 : {16'd0, dabs[32:17]};
        pipe_d[0].dv[2*a+b].quo = '0;
        pipe_d[0].dv[2*a+b].nlo = {dabs[16:0], 16'd0};
      end
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    always_comb begin
      pipe_d[k+1] = pipe_q[k];
      for (int l = 0; l < NumDivs; l++) begin
        pipe_d[k+1].dv[l] = div_step(pipe_q[k].dv[l]);
      end
    end
  end

  for (genvar k = 0; k <= DivSteps; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pipe_q[k] <= '0;
      end else if (en) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  always_comb begin
    logic [31:0] t0;
    logic [31:0] t1;
    sort_d       = '0;
    sort_d.valid = pipe_q[DivSteps].valid;
    sort_d.par   = pipe_q[DivSteps].par;
    sort_d.ins   = pipe_q[DivSteps].ins;
    for (int a = 0; a < NumAxes; a++) begin
      t0 = div_sat(pipe_q[DivSteps].dv[2*a]);
      t1 = div_sat(pipe_q[DivSteps].dv[2*a+1]);
      if ($signed(t0) > $signed(t1)) begin
        sort_d.lo[a] = t1;
        sort_d.hi[a] = t0;
      end else begin
        sort_d.lo[a] = t0;
        sort_d.hi[a] = t1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_q <= '0;
    end else if (en) begin
      sort_q <= sort_d;
    end
  end

  always_comb begin
    logic [31:0] near_t;
    logic [31:0] far_t;
    logic        ok;
    near_t = 32'd0;
    far_t  = 32'h7FFF_FFFF;
    ok     = 1'b1;
    for (int a = 0; a < NumAxes; a++) begin
      if (sort_q.par[a]) begin
        ok = ok && sort_q.ins[a];
      end else begin
        if ($signed(sort_q.lo[a]) > $signed(near_t)) begin
          near_t = sort_q.lo[a];
        end
        if ($signed(sort_q.hi[a]) < $signed(far_t)) begin
          far_t = sort_q.hi[a];
        end
      end
    end
    out_hit_d  = ok && ($signed(near_t) <= $signed(far_t));
    out_dist_d = out_hit_d ? near_t[30:0] : 31'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_dist_q  <= '0;
    end else if (en) begin
      out_valid_q <= sort_q.valid;
      out_hit_q   <= out_hit_d;
      out_dist_q  <= out_dist_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = {1'b0, out_dist_q};

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_hit_q |-> out_dist_q == 31'd0)
    else $error("miss with nonzero entry distance");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!out_valid_q || m_axis_tready))
    else $error("input ready does not follow pipeline enable");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> pipe_q[0].valid)
    else $error("accepted transaction did not enter the pipeline");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(sort_q))
    else $error("pipeline moved while stalled");
`endif

endmodule

### verif/ray_box_slab_intersect_tb.sv
module ray_box_slab_intersect_tb;
  import rbsi_pkg::*;

  localparam logic [2:0] CfgUnused = 3'd7;
  localparam int unsigned Latency = 40;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned PhaseRays = 75;

  typedef struct packed {
    logic        hit;
    logic [30:0] entry;
  } hit_rec_t;

  typedef struct {
    logic [31:0] ox, oy, oz, dx, dy, dz;
    bit          known;
    hit_rec_t    want;
  } row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;

  ray_box_slab_intersect uut (.*);

  longint          box_lo [3];
  longint          box_hi [3];
  longint unsigned par_thr;
  hit_rec_t        pending_hits [$];
  int              fails;
  int              results_seen;
  int              idle_cycles;
  bit              quiet;
  bit              row_known;
  hit_rec_t        row_want;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint slab_dist(longint diff, longint dv);
    longint unsigned num, den, q;
    bit              neg;
    num = (diff < 0 ? -diff : diff) << 16;
    den = dv < 0 ? -dv : dv;
    q   = num / den;
    neg = (diff < 0) != (dv < 0);
    if (neg) return (q > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
    return (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
  endfunction

  function automatic hit_rec_t trace_ray(logic [191:0] d);
    longint   near_t, far_t, o, dv, t0, t1, tmp;
    bit       hit;
    hit_rec_t r;
    near_t = 0;
    far_t  = 64'sh7FFF_FFFF;
    hit    = 1'b1;
    for (int a = 0; a < 3 && hit; a++) begin
      o  = sx32(d[32*a +: 32]);
      dv = sx32(d[32*(a+3) +: 32]);
      if (dv == 0 || longint'(dv < 0 ? -dv : dv) < longint'(par_thr)) begin
        if (o < box_lo[a] || o > box_hi[a]) hit = 1'b0;
      end else begin
        t0 = slab_dist(box_lo[a] - o, dv);
        t1 = slab_dist(box_hi[a] - o, dv);
        if (t0 > t1) begin
          tmp = t0;
          t0  = t1;
          t1  = tmp;
        end
        if (t0 > near_t) near_t = t0;
        if (t1 < far_t) far_t = t1;
        if (near_t > far_t) hit = 1'b0;
      end
    end
    r.hit   = hit;
    r.entry = hit ? near_t[30:0] : '0;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  always @(posedge clk_i) begin
    hit_rec_t w;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_BOX_MIN_X, CFG_BOX_MIN_Y, CFG_BOX_MIN_Z:
            box_lo[cfg_index_i] = sx32(cfg_data_i);
          CFG_BOX_MAX_X, CFG_BOX_MAX_Y, CFG_BOX_MAX_Z:
            box_hi[cfg_index_i - 3] = sx32(cfg_data_i);
          CFG_PAR_THR: par_thr = {33'd0, cfg_data_i[30:0]};
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_hits.push_back(row_known ? row_want : trace_ray(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_hits.size() == 0) begin
          $error("Result transaction with no expectation waiting");
          fails++;
        end else begin
          w = pending_hits.pop_front();
          if (m_axis_tuser !== w.hit) begin
            $error("hit: expected %0d, actual %0d", w.hit, m_axis_tuser);
            fails++;
          end
          if (m_axis_tdata !== {1'b0, w.entry}) begin
            $error("entry_distance: expected %0h, actual %0h", {1'b0, w.entry}, m_axis_tdata);
            fails++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    bit held;
    int gap;
    held = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (Latency) @(negedge clk_i);
  endtask

  task automatic send_ray(logic [191:0] d);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic set_box(longint lo [3], longint hi [3], logic [31:0] thr);
    for (int a = 0; a < 3; a++) begin
      write_reg(3'(CFG_BOX_MIN_X + a), clamp32(lo[a]));
      write_reg(3'(CFG_BOX_MAX_X + a), clamp32(hi[a]));
    end
    write_reg(CFG_PAR_THR, thr);
  endtask

  function automatic logic [191:0] random_ray();
    longint tgt, org, span, dv;
    logic [191:0] d;
    int p;
    p = $urandom_range(0, 99);
    if (p < 20) return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    for (int a = 0; a < 3; a++) begin
      span = box_hi[a] - box_lo[a];
      if (span > 0) tgt = box_lo[a] + longint'({$urandom, $urandom} % (span + 1));
      else tgt = box_lo[a];
      if ($urandom_range(0, 9) == 0) begin
        d[32*a +: 32]     = clamp32(tgt);
        d[32*(a+3) +: 32] = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 255);
      end else begin
        org = tgt + longint'($urandom_range(0, 80 << 16)) - (40 << 16);
        dv  = (tgt - org) >>> $urandom_range(0, 8);
        if ($urandom_range(0, 7) == 0) dv = -dv;
        d[32*a +: 32]     = clamp32(org);
        d[32*(a+3) +: 32] = clamp32(dv);
      end
    end
    return d;
  endfunction

  initial begin
    row_t   rows [$];
    longint lo [3], hi [3];
    longint c, h;
    logic [31:0] thr;
    fails = 0;
    results_seen = 0;
    idle_cycles = 0;
    quiet = 1'b1;
    row_known = 1'b0;
    row_want = '0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_BOX_MIN_X;
    cfg_data_i = '0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 0;
    end
    par_thr = 1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Box and threshold at their reset values: the box is the single point at zero.
    rows = '{
      '{0, 0, 0, 0, 0, 0, 1, '{1'b1, 31'd0}},
      '{1, 0, 0, 0, 0, 0, 1, '{1'b0, 31'd0}},
      '{32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1, '{1'b0, 31'd0}},
      '{0, 0, 32'h7FFF_FFFF, 0, 0, 0, 1, '{1'b0, 31'd0}},
      '{0, 32'h8000_0000, 0, 0, 0, 0, 1, '{1'b0, 31'd0}},
      '{0, 0, 0, 1, 0, 0, 1, '{1'b1, 31'd0}},
      '{0, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, '{1'b1, 31'd0}},
      '{32'h8000_0000, 0, 0, 1, 0, 0, 1, '{1'b1, 31'h7FFF_FFFF}}
    };
    foreach (rows[i]) begin
      row_known = rows[i].known;
      row_want  = rows[i].want;
      send_ray({rows[i].dz, rows[i].dy, rows[i].dx, rows[i].oz, rows[i].oy, rows[i].ox});
    end
    s_axis_tvalid <= 1'b0;
    row_known = 1'b0;
    drain();

    lo = '{-(10 << 16), -(10 << 16), -(10 << 16)};
    hi = '{10 << 16, 10 << 16, 10 << 16};
    set_box(lo, hi, 32'h0000_0100);
    write_reg(CfgUnused, 32'hDEAD_BEEF);
    rows = '{
      '{32'h8000_0000, 0, 0, 1, 0, 0, 0, '0},
      '{32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, '0},
      '{32'hFFEC_0000, 0, 0, 32'h0001_0000, 0, 0, 0, '0},
      '{32'hFFEC_0000, 32'hFFEC_0000, 32'hFFEC_0000, 32'h10000, 32'h10000, 32'h10000, 0, '0},
      '{0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '0},
      '{0, 0, 0, 32'hFF, 32'h100, 32'hFFFF_FF01, 0, '0},
      '{32'h000A_0000, 32'h000A_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, '0},
      '{32'h000A_0001, 0, 0, 0, 0, 0, 0, '0},
      '{32'h0014_0000, 0, 0, 32'hFFFF_0000, 32'h0, 32'h0, 0, '0},
      '{32'h0014_0000, 0, 0, 32'h0001_0000, 32'h0, 32'h0, 0, '0}
    };
    foreach (rows[i])
      send_ray({rows[i].dz, rows[i].dy, rows[i].dx, rows[i].oz, rows[i].oy, rows[i].ox});
    s_axis_tvalid <= 1'b0;
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      quiet = (ph == 1);
      for (int a = 0; a < 3; a++) begin
        c = longint'($urandom_range(0, 60 << 16)) - (30 << 16);
        h = longint'($urandom_range(1, 20 << 16));
        lo[a] = c - h;
        hi[a] = c + h;
        if (ph == 3 && a == 1) begin
          lo[a] = c + h;
          hi[a] = c - h;
        end
        if (ph == 4) begin
          lo[a] = -64'sh8000_0000;
          hi[a] = 64'sh7FFF_FFFF;
        end
      end
      case (ph)
        0: thr = 32'd0;
        2: thr = 32'h7FFF_FFFF;
        5: thr = 32'd1;
        default: thr = $urandom_range(0, 1 << 12);
      endcase
      set_box(lo, hi, thr);
      for (int n = 0; n < PhaseRays; n++) send_ray(random_ray());
      s_axis_tvalid <= 1'b0;
      drain();
    end

    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rbsi_pkg.sv
hw/rtl/ray_box_slab_intersect.sv
verif/ray_box_slab_intersect_tb.sv
